// ===== rtl/core/ipdf_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipdf_pkg
// Shared types, constants and helpers of the isolated pixel deglitch filter.
// ---------------------------------------------------------------------------
package ipdf_pkg;

    localparam int LVL_W     = 4;   // gray level width
    localparam int POS_W     = 6;   // internal row / column counters
    localparam int OUT_POS_W = 5;   // row / column fields of a result word
    localparam int CFG_W     = 6;   // widest configuration register
    localparam int CFG_IDX_W = 1;
    localparam int SUM_W     = 6;   // sum of up to four levels
    localparam int CNT_W     = 3;   // up to four neighbors

    localparam logic [CFG_W-1:0] CFG_W_RESET = 6'd30;
    localparam logic [CFG_W-1:0] CFG_H_RESET = 6'd20;

    // scaled reciprocal of 6 (2 * 3) for the rounded mean of three neighbors
    localparam logic [7:0] RECIP3    = 8'd171;
    localparam int         RECIP3_SH = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        TAP_CTR = 3'd0,
        TAP_UP  = 3'd1,
        TAP_DN  = 3'd2,
        TAP_LF  = 3'd3,
        TAP_RT  = 3'd4
    } t_tap;

    typedef struct packed {
        logic                 wr_en;
        logic                 rd_en;
        t_tap                 tap;
        logic [1:0]           slot;
        logic [POS_W-1:0]     col;
        logic                 load_out;
        logic [OUT_POS_W-1:0] out_row;
        logic [OUT_POS_W-1:0] out_col;
        logic                 out_done;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

    function automatic logic [1:0] slot_prev(input logic [1:0] s);
        return (s == 2'd0) ? 2'd2 : s - 2'd1;
    endfunction

    function automatic logic [1:0] slot_next(input logic [1:0] s);
        return (s == 2'd2) ? 2'd0 : s + 2'd1;
    endfunction

endpackage

// ===== rtl/core/ipdf_pix_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipdf_pix_if
// Input pixel channel: valid / ready with one gray level per word.
// ---------------------------------------------------------------------------
interface ipdf_pix_if;
    logic                      valid;
    logic                      ready;
    logic [ipdf_pkg::LVL_W-1:0] pixel_level;

    modport source (output valid, output pixel_level, input ready);
    modport sink   (input valid, input pixel_level, output ready);
endinterface

// ===== rtl/core/ipdf_res_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipdf_res_if
// Result channel: filtered level with its row, column and end-of-frame flag.
// ---------------------------------------------------------------------------
interface ipdf_res_if;
    logic                           valid;
    logic                           ready;
    logic [ipdf_pkg::LVL_W-1:0]     filtered_level;
    logic [ipdf_pkg::OUT_POS_W-1:0] out_row;
    logic [ipdf_pkg::OUT_POS_W-1:0] out_col;
    logic                           frame_done;

    modport source (output valid, output filtered_level, output out_row,
                    output out_col, output frame_done, input ready);
    modport sink   (input valid, input filtered_level, input out_row,
                    input out_col, input frame_done, output ready);
endinterface

// ===== rtl/core/ipdf_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipdf_datapath
// Three-row line store, neighbor accumulation, rounded mean and result register.
// ---------------------------------------------------------------------------
module ipdf_datapath #(
    parameter int MAX_COLS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ipdf_pkg::t_dp_cmd          i_cmd,
    output ipdf_pkg::t_dp_stat         o_stat,
    input  logic [ipdf_pkg::LVL_W-1:0] i_pixel_level,
    ipdf_res_if.source                 o_res
);
    import ipdf_pkg::*;

    localparam int DEPTH = 3 * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);

    logic [LVL_W-1:0] r_row_store [DEPTH];
    logic [AW-1:0]    addr;

    logic [LVL_W-1:0] r_rd_data;
    logic             r_rd_vld;
    t_tap             r_rd_tap;

    logic [LVL_W-1:0] r_ctr;
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_cnt;
    logic             r_pass;

    logic [LVL_W-1:0] diff;
    logic [6:0]       twice_plus;
    logic [14:0]      prod3;
    logic [6:0]       sum_p1;
    logic [6:0]       sum_p2;
    logic [LVL_W-1:0] result;

    logic                 r_out_valid;
    logic [LVL_W-1:0]     r_out_level;
    logic [OUT_POS_W-1:0] r_out_row;
    logic [OUT_POS_W-1:0] r_out_col;
    logic                 r_out_done;

    always_comb begin
        case (i_cmd.slot)
            2'd1:    addr = AW'(MAX_COLS) + AW'(i_cmd.col);
            2'd2:    addr = AW'(2 * MAX_COLS) + AW'(i_cmd.col);
            default: addr = AW'(i_cmd.col);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_row_store[addr] <= i_pixel_level;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_row_store[addr];
        end
        r_rd_tap <= i_cmd.tap;
    end

    assign diff = (r_rd_data > r_ctr) ? r_rd_data - r_ctr : r_ctr - r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
        end
    end

    // accumulate far neighbors, one store word per cycle
    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            if (r_rd_tap == TAP_CTR) begin
                r_ctr  <= r_rd_data;
                r_sum  <= '0;
                r_cnt  <= '0;
                r_pass <= 1'b0;
            end else if (diff <= LVL_W'(1)) begin
                r_pass <= 1'b1;
            end else begin
                r_sum <= r_sum + SUM_W'(r_rd_data);
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    // floor((2*sum + n) / (2*n))
    assign twice_plus = {1'b0, r_sum} + {1'b0, r_sum} + 7'(r_cnt);
    assign prod3      = 15'(twice_plus) * 15'(RECIP3);
    assign sum_p1     = {1'b0, r_sum} + 7'd1;
    assign sum_p2     = {1'b0, r_sum} + 7'd2;

    always_comb begin
        result = r_ctr;
        if (!r_pass) begin
            case (r_cnt)
                3'd1:    result = r_sum[LVL_W-1:0];
                3'd2:    result = sum_p1[LVL_W:1];
                3'd3:    result = prod3[RECIP3_SH+LVL_W-1:RECIP3_SH];
                3'd4:    result = sum_p2[LVL_W+1:2];
                default: result = r_ctr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_level <= result;
            r_out_row   <= i_cmd.out_row;
            r_out_col   <= i_cmd.out_col;
            r_out_done  <= i_cmd.out_done;
        end
    end

    assign o_stat.out_free     = !r_out_valid || o_res.ready;
    assign o_res.valid          = r_out_valid;
    assign o_res.filtered_level = r_out_level;
    assign o_res.out_row        = r_out_row;
    assign o_res.out_col        = r_out_col;
    assign o_res.frame_done     = r_out_done;

endmodule

// ===== rtl/core/ipdf_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipdf_ctrl
// Frame counters, configuration registers and the per-pixel read sequencer.
// ---------------------------------------------------------------------------
module ipdf_ctrl #(
    parameter int MAX_COLS = 32,
    parameter int MAX_ROWS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ipdf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ipdf_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    output ipdf_pkg::t_dp_cmd              o_cmd,
    input  ipdf_pkg::t_dp_stat             i_stat
);
    import ipdf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_EMIT
    } t_state;

    t_state           r_state;
    logic [CFG_W-1:0] r_cfg_w;
    logic [CFG_W-1:0] r_cfg_h;

    // position of the next input word
    logic [POS_W-1:0] r_col;
    logic [POS_W-1:0] r_row;
    logic [1:0]       r_slot;

    // pixel being filtered
    logic [POS_W-1:0] r_jcol;
    logic [POS_W-1:0] r_jrow;
    logic [1:0]       r_jslot;
    logic             r_flush;
    t_tap             r_step;

    // final row, flushed after the last word of the frame
    logic             r_last;
    logic [POS_W-1:0] r_frow;
    logic [1:0]       r_fslot;

    logic [POS_W-1:0] eff_w;
    logic [POS_W-1:0] eff_h;
    logic             col_end;
    logic             row_end;

    always_comb begin
        if (r_cfg_w < POS_W'(2)) begin
            eff_w = POS_W'(2);
        end else if (r_cfg_w > POS_W'(MAX_COLS)) begin
            eff_w = POS_W'(MAX_COLS);
        end else begin
            eff_w = r_cfg_w;
        end
        if (r_cfg_h < POS_W'(2)) begin
            eff_h = POS_W'(2);
        end else if (int'(r_cfg_h) > MAX_ROWS) begin
            eff_h = POS_W'(MAX_ROWS);
        end else begin
            eff_h = r_cfg_h;
        end
    end

    assign col_end    = (r_col == eff_w - POS_W'(1));
    assign row_end    = (r_row == eff_h - POS_W'(1));
    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg_w <= CFG_W_RESET;
            r_cfg_h <= CFG_H_RESET;
            r_col   <= '0;
            r_row   <= '0;
            r_slot  <= 2'd0;
            r_last  <= 1'b0;
            r_flush <= 1'b0;
            r_step  <= TAP_CTR;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_WIDTH:  r_cfg_w <= i_cfg_data;
                CFG_HEIGHT: r_cfg_h <= i_cfg_data;
            endcase
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= 2'd0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (col_end) begin
                            r_col <= '0;
                            if (row_end) begin
                                r_row  <= '0;
                                r_slot <= 2'd0;
                            end else begin
                                r_row  <= r_row + POS_W'(1);
                                r_slot <= slot_next(r_slot);
                            end
                        end else begin
                            r_col <= r_col + POS_W'(1);
                        end
                        r_last  <= col_end && row_end;
                        r_frow  <= r_row;
                        r_fslot <= r_slot;
                        // the pixel above this one is now complete
                        if (r_row != '0) begin
                            r_jrow  <= r_row - POS_W'(1);
                            r_jcol  <= r_col;
                            r_jslot <= slot_prev(r_slot);
                            r_flush <= 1'b0;
                            r_step  <= TAP_CTR;
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    unique case (r_step)
                        TAP_CTR: r_step <= TAP_UP;
                        TAP_UP:  r_step <= TAP_DN;
                        TAP_DN:  r_step <= TAP_LF;
                        TAP_LF:  r_step <= TAP_RT;
                        default: r_state <= S_WAIT;
                    endcase
                end
                S_WAIT: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (i_stat.out_free) begin
                        r_step <= TAP_CTR;
                        if (!r_flush && r_last) begin
                            r_flush <= 1'b1;
                            r_jrow  <= r_frow;
                            r_jslot <= r_fslot;
                            r_jcol  <= '0;
                            r_state <= S_READ;
                        end else if (r_flush && (r_jcol + POS_W'(1) < eff_w)) begin
                            r_jcol  <= r_jcol + POS_W'(1);
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.tap      = r_step;
        o_cmd.slot     = r_jslot;
        o_cmd.col      = r_jcol;
        o_cmd.out_row  = OUT_POS_W'(r_jrow);
        o_cmd.out_col  = OUT_POS_W'(r_jcol);
        o_cmd.out_done = r_flush && (r_jcol == eff_w - POS_W'(1));
        unique case (r_state)
            S_IDLE: begin
                o_cmd.wr_en = i_in_valid && !i_cfg_we;
                o_cmd.slot  = r_slot;
                o_cmd.col   = r_col;
            end
            S_READ: begin
                // absent neighbors are not read
                unique case (r_step)
                    TAP_CTR: o_cmd.rd_en = 1'b1;
                    TAP_UP: begin
                        o_cmd.rd_en = (r_jrow != '0);
                        o_cmd.slot  = slot_prev(r_jslot);
                    end
                    TAP_DN: begin
                        o_cmd.rd_en = (r_jrow + POS_W'(1) < eff_h);
                        o_cmd.slot  = slot_next(r_jslot);
                    end
                    TAP_LF: begin
                        o_cmd.rd_en = (r_jcol != '0);
                        o_cmd.col   = r_jcol - POS_W'(1);
                    end
                    default: begin
                        o_cmd.rd_en = (r_jcol + POS_W'(1) < eff_w);
                        o_cmd.col   = r_jcol + POS_W'(1);
                    end
                endcase
            end
            S_WAIT: begin
                o_cmd.rd_en = 1'b0;
            end
            S_EMIT: begin
                o_cmd.load_out = i_stat.out_free;
            end
        endcase
    end

endmodule

// ===== rtl/core/image_pixel_deglitch_filter.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// image_pixel_deglitch_filter
// Streaming four-neighbor isolated pixel deglitch over a raster frame.
// ---------------------------------------------------------------------------
// Pixels enter in raster order and each result word leaves one row late with
// its row, column and an end-of-frame flag. A pixel with a present up, down,
// left or right neighbor within one level of it passes; otherwise it becomes
// the rounded mean of its present neighbors. Every word is written into the
// three-row line store; each word after the first row then starts a result:
// reads of the pixel above it and its present neighbors through the single
// read port of the line store, a settle state, and a hand-off to the output
// register that waits while the output stalls. The last word of a frame also
// flushes the final row. The input is not ready again until its results are
// handed off. A configuration write restarts the frame position.
// ---------------------------------------------------------------------------
module image_pixel_deglitch_filter #(
    parameter int MAX_COLS = 32,
    parameter int MAX_ROWS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ipdf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ipdf_pkg::CFG_W-1:0]     i_cfg_data,
    ipdf_pix_if.sink                       i_pix,
    ipdf_res_if.source                     o_res
);
    import ipdf_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    ipdf_ctrl #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    ipdf_datapath #(
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_pixel_level (i_pix.pixel_level),
        .o_res         (o_res)
    );

endmodule
